FILE: sv/dad_pkg.sv
`timescale 1ns / 1ps

package dad_pkg;

    // Fixed field widths
    localparam int ELEM_W   = 17;
    localparam int IDX_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Row layout: four box values, objectness, then class scores
    localparam logic [IDX_W-1:0] FIELD_CX    = 9'd0;
    localparam logic [IDX_W-1:0] FIELD_CY    = 9'd1;
    localparam logic [IDX_W-1:0] FIELD_W     = 9'd2;
    localparam logic [IDX_W-1:0] FIELD_H     = 9'd3;
    localparam logic [IDX_W-1:0] FIELD_OBJ   = 9'd4;
    localparam logic [IDX_W-1:0] BOX_FIELDS  = 9'd5;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd6;

    typedef struct packed {
        logic [15:0] score_threshold;
        logic [7:0]  class_count;
        logic [11:0] pad_left;
        logic [11:0] pad_top;
        logic [23:0] inverse_scale;
        logic [13:0] image_width;
        logic [13:0] image_height;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_CALC,
        ST_EMIT
    } state_t;

    // Datapath steps after row end, in issue order
    typedef enum logic [3:0] {
        OP_SCORE,
        OP_CX,
        OP_SW,
        OP_CXI,
        OP_SWI,
        OP_EDGEX,
        OP_CY,
        OP_SH,
        OP_CYI,
        OP_SHI,
        OP_EDGEY
    } op_t;

    typedef struct packed {
        logic capture;
        logic op_en;
        op_t  op;
        logic load;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic row_last;
        logic reject;
        logic out_free;
    } dp_status_t;

endpackage

FILE: sv/dad_regs.sv
`timescale 1ns / 1ps

module dad_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dad_pkg::CFG_DATA_W-1:0] cfg_data,
    output dad_pkg::cfg_t                  cfg
);
    import dad_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCORE_THRESHOLD: cfg_next.score_threshold = cfg_data[15:0];
                CFG_CLASS_COUNT:     cfg_next.class_count     = cfg_data[7:0];
                CFG_PAD_LEFT:        cfg_next.pad_left        = cfg_data[11:0];
                CFG_PAD_TOP:         cfg_next.pad_top         = cfg_data[11:0];
                CFG_INVERSE_SCALE:   cfg_next.inverse_scale   = cfg_data[23:0];
                CFG_IMAGE_WIDTH:     cfg_next.image_width     = cfg_data[13:0];
                CFG_IMAGE_HEIGHT:    cfg_next.image_height    = cfg_data[13:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.score_threshold <= 16'd19661;
            cfg_reg.class_count     <= 8'd80;
            cfg_reg.pad_left        <= 12'd0;
            cfg_reg.pad_top         <= 12'd0;
            cfg_reg.inverse_scale   <= 24'd65536;
            cfg_reg.image_width     <= 14'd640;
            cfg_reg.image_height    <= 14'd640;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/dad_ctrl.sv
`timescale 1ns / 1ps

module dad_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dad_pkg::dp_status_t  status,
    output dad_pkg::ctrl_cmd_t   cmd
);
    import dad_pkg::*;

    state_t state_reg;
    state_t state_next;
    op_t    step_reg;
    op_t    step_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (in_valid && status.row_last)
                begin
                    state_next = ST_CALC;
                    step_next  = OP_SCORE;
                end
            end
            ST_CALC:
            begin
                if (step_reg == OP_EDGEY)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = op_t'(step_reg + 4'd1);
                end
            end
            ST_EMIT:
            begin
                if (status.reject || status.out_free)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall    = 1'b1;
        cmd.capture = 1'b0;
        cmd.op_en   = 1'b0;
        cmd.op      = step_reg;
        cmd.load    = 1'b0;
        cmd.clear   = 1'b0;
        case (state_reg)
            ST_ACCUM:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_CALC:
            begin
                cmd.op_en = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.load  = !status.reject && status.out_free;
                cmd.clear = status.reject || status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            step_reg  <= OP_SCORE;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: sv/dad_datapath.sv
`timescale 1ns / 1ps

module dad_datapath #(
    parameter int NET_WIDTH   = 640,
    parameter int NET_HEIGHT  = 640,
    parameter int MAX_CLASSES = 255
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dad_pkg::cfg_t               cfg,
    input  dad_pkg::ctrl_cmd_t          cmd,
    output dad_pkg::dp_status_t         status,
    input  logic [dad_pkg::ELEM_W-1:0]  element_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [14:0]                 box_left,
    output logic [14:0]                 box_top,
    output logic signed [15:0]          box_width,
    output logic signed [15:0]          box_height,
    output logic signed [8:0]           class_index,
    output logic [15:0]                 box_score
);
    import dad_pkg::*;

    localparam logic [7:0] MaxCc = 8'(MAX_CLASSES);

    function automatic logic signed [15:0] sat16(input logic signed [26:0] v);
        logic signed [15:0] r;
        if (v > 27'sd32767)
            r = 16'sd32767;
        else if (v < -27'sd32768)
            r = -16'sd32768;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [14:0] sat15(input logic [24:0] v);
        return (v > 25'd32767) ? 15'd32767 : v[14:0];
    endfunction

    // Row capture
    logic [IDX_W-1:0]  elem_idx_reg;
    logic [ELEM_W-1:0] cx_reg, cy_reg, sw_reg, sh_reg, obj_reg, best_reg;
    logic              rejected_reg;
    logic signed [8:0] best_class_reg;

    // Arithmetic
    logic [17:0]         score_reg;
    logic signed [31:0]  c_reg;
    logic [31:0]         s_reg;
    logic signed [56:0]  c32_reg;
    logic signed [56:0]  s32_reg;
    logic [24:0]         left_x_reg, ext_x_reg, left_y_reg, ext_y_reg;

    // Output stage
    logic               out_valid_reg;
    logic [14:0]        left_out_reg, top_out_reg;
    logic signed [15:0] width_out_reg, height_out_reg;
    logic signed [8:0]  class_out_reg;
    logic [15:0]        score_out_reg;

    logic [7:0]         cc;
    logic [IDX_W-1:0]   last_idx;
    logic signed [31:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [56:0] prod;
    logic signed [57:0] diff;
    logic [24:0]        edge_val;
    logic signed [26:0] lim_x, lim_y, wclip, hclip;

    assign cc       = (cfg.class_count > MaxCc) ? MaxCc : cfg.class_count;
    assign last_idx = FIELD_OBJ + {1'b0, cc};

    assign status.row_last = (elem_idx_reg >= last_idx);
    assign status.reject   = rejected_reg || (score_reg < {2'b00, cfg.score_threshold});
    assign status.out_free = !out_valid_reg || !out_stall;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = 32'sd0;
        mul_b = 25'sd0;
        case (cmd.op)
            OP_SCORE:
            begin
                mul_a = $signed({15'd0, obj_reg});
                mul_b = $signed({8'd0, best_reg});
            end
            OP_CX:
            begin
                mul_a = $signed({15'd0, cx_reg});
                mul_b = 25'(NET_WIDTH);
            end
            OP_SW:
            begin
                mul_a = $signed({15'd0, sw_reg});
                mul_b = 25'(NET_WIDTH);
            end
            OP_CY:
            begin
                mul_a = $signed({15'd0, cy_reg});
                mul_b = 25'(NET_HEIGHT);
            end
            OP_SH:
            begin
                mul_a = $signed({15'd0, sh_reg});
                mul_b = 25'(NET_HEIGHT);
            end
            OP_CXI, OP_CYI:
            begin
                mul_a = c_reg;
                mul_b = $signed({1'b0, cfg.inverse_scale});
            end
            OP_SWI, OP_SHI:
            begin
                mul_a = $signed(s_reg);
                mul_b = $signed({1'b0, cfg.inverse_scale});
            end
            default:
            begin
                mul_a = 32'sd0;
                mul_b = 25'sd0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // (2c - s) / 2^33; a negative edge clips to zero anyway
    assign diff     = $signed({c32_reg, 1'b0}) - $signed({s32_reg[56], s32_reg});
    assign edge_val = diff[57] ? 25'd0 : diff[57:33];

    assign lim_x = $signed({13'd0, cfg.image_width})  - $signed({2'b00, left_x_reg});
    assign lim_y = $signed({13'd0, cfg.image_height}) - $signed({2'b00, left_y_reg});
    assign wclip = (lim_x < $signed({2'b00, ext_x_reg})) ? lim_x : $signed({2'b00, ext_x_reg});
    assign hclip = (lim_y < $signed({2'b00, ext_y_reg})) ? lim_y : $signed({2'b00, ext_y_reg});

    // Row control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_idx_reg   <= '0;
            rejected_reg   <= 1'b0;
            best_reg       <= '0;
            best_class_reg <= -9'sd1;
            cx_reg         <= '0;
            cy_reg         <= '0;
            sw_reg         <= '0;
            sh_reg         <= '0;
            obj_reg        <= '0;
        end
        else if (cmd.clear)
        begin
            rejected_reg   <= 1'b0;
            best_reg       <= '0;
            best_class_reg <= -9'sd1;
        end
        else if (cmd.capture)
        begin
            elem_idx_reg <= status.row_last ? '0 : elem_idx_reg + 9'd1;
            case (elem_idx_reg)
                FIELD_CX: cx_reg <= element_value;
                FIELD_CY: cy_reg <= element_value;
                FIELD_W:  sw_reg <= element_value;
                FIELD_H:  sh_reg <= element_value;
                FIELD_OBJ:
                begin
                    obj_reg <= element_value;
                    if (element_value < {1'b0, cfg.score_threshold})
                        rejected_reg <= 1'b1;
                end
                default:
                begin
                    if (element_value > best_reg)
                    begin
                        best_reg       <= element_value;
                        best_class_reg <= $signed(elem_idx_reg - BOX_FIELDS);
                    end
                end
            endcase
        end
    end

    // Step results
    always_ff @(posedge clk)
    begin
        if (cmd.op_en)
        begin
            case (cmd.op)
                OP_SCORE:       score_reg <= prod[33:16];
                OP_CX, OP_CY:
                begin
                    if (cmd.op == OP_CX)
                        c_reg <= prod[31:0] - $signed({4'd0, cfg.pad_left, 16'd0});
                    else
                        c_reg <= prod[31:0] - $signed({4'd0, cfg.pad_top, 16'd0});
                end
                OP_SW, OP_SH:   s_reg   <= prod[31:0];
                OP_CXI, OP_CYI: c32_reg <= prod;
                OP_SWI, OP_SHI: s32_reg <= prod;
                OP_EDGEX:
                begin
                    left_x_reg <= edge_val;
                    ext_x_reg  <= s32_reg[56:32];
                end
                OP_EDGEY:
                begin
                    left_y_reg <= edge_val;
                    ext_y_reg  <= s32_reg[56:32];
                end
                default:
                begin
                    score_reg <= score_reg;
                end
            endcase
        end
    end

    // Output stage: clip and saturate on load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            left_out_reg   <= sat15(left_x_reg);
            top_out_reg    <= sat15(left_y_reg);
            width_out_reg  <= sat16(wclip);
            height_out_reg <= sat16(hclip);
            class_out_reg  <= best_class_reg;
            score_out_reg  <= (score_reg > 18'd65535) ? 16'hFFFF : score_reg[15:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign box_left    = left_out_reg;
    assign box_top     = top_out_reg;
    assign box_width   = width_out_reg;
    assign box_height  = height_out_reg;
    assign class_index = class_out_reg;
    assign box_score   = score_out_reg;

endmodule

FILE: sv/detector_anchor_decode_top.sv
`timescale 1ns / 1ps

// Anchor-row decoder with letterbox undo. Elements of one row stream in on
// element_value, one beat per cycle: centre x, centre y, width, height,
// objectness, then class_count class scores (Q1.16). The block tracks the
// arg-max class, and at the row's last beat stalls the input while one shared
// 32x25 multiplier runs eleven steps (score, then per axis: scale to network
// size with padding removed, scale of size, two inverse-scale products and an
// edge step), followed by an emit state that clips, saturates and loads the
// output register; a kept row waits there while a previous box still waits
// on out_stall. Rows whose objectness or score falls below score_threshold
// give no box. Registers are written through cfg_valid/cfg_ready (always
// ready) and should be changed only between rows.

module detector_anchor_decode_top #(
    parameter int NET_WIDTH   = 640,
    parameter int NET_HEIGHT  = 640,
    parameter int MAX_CLASSES = 255
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dad_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dad_pkg::ELEM_W-1:0]     element_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [14:0]                    box_left,
    output logic [14:0]                    box_top,
    output logic signed [15:0]             box_width,
    output logic signed [15:0]             box_height,
    output logic signed [8:0]              class_index,
    output logic [15:0]                    box_score
);
    import dad_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // register file
    dad_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: row capture, calc steps, emit
    dad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // row state, shared multiplier, output register
    dad_datapath #(
        .NET_WIDTH   (NET_WIDTH),
        .NET_HEIGHT  (NET_HEIGHT),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .box_left      (box_left),
        .box_top       (box_top),
        .box_width     (box_width),
        .box_height    (box_height),
        .class_index   (class_index),
        .box_score     (box_score)
    );

endmodule

FILE: sv/dad_checker.sv
`timescale 1ns / 1ps

module dad_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [dad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [dad_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [dad_pkg::ELEM_W-1:0]     element_value,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [14:0]                    box_left,
    input logic [14:0]                    box_top,
    input logic signed [15:0]             box_width,
    input logic signed [15:0]             box_height,
    input logic signed [8:0]              class_index,
    input logic [15:0]                    box_score
);

    // held box stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("box dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(box_left) && $stable(box_top)
            && $stable(box_width) && $stable(box_height)
            && $stable(class_index) && $stable(box_score))
        else $error("stalled box changed");

    // input stalls only after a row's last beat was taken
    a_stall_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stalled without an accepted beat");

    // a new box appears only out of the row-end calculation
    a_box_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("box emitted outside row-end calculation");

endmodule

bind detector_anchor_decode_top dad_checker u_chk (.*);
